### design/obdpr_pkg.sv
// ----------------------------------------------------------------------------
// obdpr_pkg
// Shared types and constants for the diagnostic request responder.
// ----------------------------------------------------------------------------
`default_nettype none

package obdpr_pkg;

  // service modes
  localparam logic [7:0] MODE_CURRENT   = 8'h01;
  localparam logic [7:0] MODE_STORED    = 8'h03;
  localparam logic [7:0] MODE_PENDING   = 8'h07;
  localparam logic [7:0] MODE_PERMANENT = 8'h0A;
  localparam logic [7:0] SERVICE_OFS    = 8'h40;

  // identifiers
  localparam logic [10:0] ID_REQ_BASE  = 11'h7E0;
  localparam logic [10:0] ID_RESP_DFLT = 11'h7E8;
  localparam logic [10:0] ID_RESP_OFS  = 11'd8;

  // slot map
  localparam logic [5:0] SLOT_CODE_BASE  = 6'd32;
  localparam logic [5:0] SLOT_COUNT_BASE = 6'd41;
  localparam logic [5:0] SLOT_END        = 6'd44;

  localparam int unsigned NUM_VALUES = 32;
  localparam int unsigned NUM_CODES  = 9;
  localparam int unsigned NUM_LISTS  = 3;

  // supported pid bitmaps
  localparam logic [31:0] BITMAP_00 = 32'hBFFF8013;
  localparam logic [31:0] BITMAP_20 = 32'h8002A001;
  localparam logic [31:0] BITMAP_40 = 32'h461C4015;
  localparam logic [31:0] BITMAP_60 = 32'h00000000;

  typedef enum logic [3:0] {
    ENC_NONE,
    ENC_BITMAP,
    ENC_WORD,
    ENC_FUEL_SYS,
    ENC_PERCENT,
    ENC_TEMP,
    ENC_TRIM,
    ENC_TIMING,
    ENC_DIV3,
    ENC_BYTE,
    ENC_RPM,
    ENC_HALF,
    ENC_DIV5
  } enc_t;

  typedef struct packed {
    enc_t        enc;
    logic [4:0]  src;
    logic [31:0] bitmap;
  } pid_info_t;

  typedef struct packed {
    logic [10:0] id;
    logic [3:0]  len;
    logic [7:0]  mode;
    logic [7:0]  pid;
  } req_t;

  // bytes[0] is the payload length byte
  typedef struct packed {
    logic            frame;
    logic [10:0]     id;
    logic [3:0]      len;
    logic [7:0][7:0] bytes;
  } resp_t;

endpackage

`default_nettype wire

### design/obd_pid_request_responder.sv
// a frame's request waits in the input stage, then is registered into the result stage that drives out_tvalid
// throughput: one item per cycle; a stalled result also holds a request in the
//   input stage that answers with a frame, while writes and silent requests pass
// value writes take effect for the very next item
// reset (rst_n low, synchronous) empties both stages and clears every
//   value, trouble code and code count to zero
// ----------------------------------------------------------------------------
// obd_pid_request_responder
// Answers diagnostic request frames from a table of vehicle values that
// update transfers keep current.
// ----------------------------------------------------------------------------
`default_nettype none

module obd_pid_request_responder #(
  parameter int unsigned CODES_PER_LIST = 3
) (
  input  var logic        clk,
  input  var logic        rst_n,
  input  var logic        in_tvalid,
  output var logic        in_tready,
  // req_id[10:0] req_len[14:11] req_mode[22:15] req_pid[30:23]
  // slot[36:31] slot_value[68:37], zero fill above
  input  var logic [71:0] in_tdata,
  // func[0]
  input  var logic        in_tuser,
  output var logic        out_tvalid,
  input  var logic        out_tready,
  // resp_id[10:0] resp_len[14:11] byte0[22:15] byte1[30:23] byte2[38:31]
  // byte3[46:39] byte4[54:47] byte5[62:55] byte6[70:63] byte7[78:71], zero above
  output var logic [79:0] out_tdata
);

  // input stage
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_func_r;
  obdpr_pkg::req_t   s1_req_r;
  logic [5:0]        s1_slot_r;
  logic [31:0]       s1_value_r;

  // tables
  logic [31:0][31:0] value_r;
  logic [8:0][15:0]  code_r;
  logic [2:0][7:0]   count_r;

  // result stage
  logic              out_valid_r, out_valid_nxt;
  obdpr_pkg::resp_t  out_resp_r;

  obdpr_pkg::resp_t  resp;
  logic              s1_res;
  logic              out_free;
  logic              s1_go;
  logic              in_xfer;
  logic              s1_write;

  obdpr_frame_build #(
    .CODES_PER_LIST (CODES_PER_LIST)
  ) u_build (
    .req    (s1_req_r),
    .values (value_r),
    .codes  (code_r),
    .counts (count_r),
    .resp   (resp)
  );

  assign s1_res    = s1_valid_r && !s1_func_r && resp.frame;
  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && (!s1_res || out_free);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_xfer   = in_tvalid && in_tready;
  assign s1_write  = s1_valid_r && s1_func_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_go && s1_res) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_func_r    <= in_tuser;
      s1_req_r.id   <= in_tdata[10:0];
      s1_req_r.len  <= in_tdata[14:11];
      s1_req_r.mode <= in_tdata[22:15];
      s1_req_r.pid  <= in_tdata[30:23];
      s1_slot_r    <= in_tdata[36:31];
      s1_value_r   <= in_tdata[68:37];
    end
    if (s1_go && s1_res) begin
      out_resp_r <= resp;
    end
  end

  // slot writes land as the update transfer leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
      code_r  <= '0;
      count_r <= '0;
    end else if (s1_write) begin
      if (s1_slot_r < obdpr_pkg::SLOT_CODE_BASE) begin
        value_r[s1_slot_r[4:0]] <= s1_value_r;
      end else if (s1_slot_r < obdpr_pkg::SLOT_COUNT_BASE) begin
        code_r[4'(s1_slot_r - obdpr_pkg::SLOT_CODE_BASE)] <= s1_value_r[15:0];
      end else if (s1_slot_r < obdpr_pkg::SLOT_END) begin
        count_r[2'(s1_slot_r - obdpr_pkg::SLOT_COUNT_BASE)] <= s1_value_r[7:0];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_resp_r.bytes, out_resp_r.len, out_resp_r.id};

endmodule

`default_nettype wire

### design/obdpr_frame_build.sv
// ----------------------------------------------------------------------------
// obdpr_frame_build
// Decodes one request against the value and code tables and forms the
// response frame: pid encodings for mode 01, code lists for 03/07/0A.
// ----------------------------------------------------------------------------
`default_nettype none

module obdpr_frame_build #(
  parameter int unsigned CODES_PER_LIST = 3
) (
  input  var obdpr_pkg::req_t   req,
  input  var logic [31:0][31:0] values,
  input  var logic [8:0][15:0]  codes,
  input  var logic [2:0][7:0]   counts,
  output var obdpr_pkg::resp_t  resp
);

  localparam logic [12:0] PCT_RECIP  = 13'd5243;   // ceil(2^19 / 100)
  localparam logic [9:0]  DIV3_RECIP = 10'd683;    // ceil(2^11 / 3)
  localparam logic [15:0] DIV5_RECIP = 16'd52429;  // ceil(2^18 / 5)
  localparam logic [1:0]  CODE_LIM   = 2'(CODES_PER_LIST);

  function automatic obdpr_pkg::pid_info_t pid_lookup(input logic [7:0] pid);
    obdpr_pkg::pid_info_t info;
    info.enc    = obdpr_pkg::ENC_NONE;
    info.src    = 5'd0;
    info.bitmap = 32'd0;
    unique case (pid)
      8'h00: begin info.enc = obdpr_pkg::ENC_BITMAP; info.bitmap = obdpr_pkg::BITMAP_00; end
      8'h20: begin info.enc = obdpr_pkg::ENC_BITMAP; info.bitmap = obdpr_pkg::BITMAP_20; end
      8'h40: begin info.enc = obdpr_pkg::ENC_BITMAP; info.bitmap = obdpr_pkg::BITMAP_40; end
      8'h60: begin info.enc = obdpr_pkg::ENC_BITMAP; info.bitmap = obdpr_pkg::BITMAP_60; end
      8'h01: begin info.enc = obdpr_pkg::ENC_WORD;     info.src = 5'd0;  end
      8'h03: begin info.enc = obdpr_pkg::ENC_FUEL_SYS; info.src = 5'd1;  end
      8'h04: begin info.enc = obdpr_pkg::ENC_PERCENT;  info.src = 5'd3;  end
      8'h05: begin info.enc = obdpr_pkg::ENC_TEMP;     info.src = 5'd4;  end
      8'h06: begin info.enc = obdpr_pkg::ENC_TRIM;     info.src = 5'd5;  end
      8'h07: begin info.enc = obdpr_pkg::ENC_TRIM;     info.src = 5'd6;  end
      8'h08: begin info.enc = obdpr_pkg::ENC_TRIM;     info.src = 5'd7;  end
      8'h09: begin info.enc = obdpr_pkg::ENC_TRIM;     info.src = 5'd8;  end
      8'h0A: begin info.enc = obdpr_pkg::ENC_DIV3;     info.src = 5'd9;  end
      8'h0B: begin info.enc = obdpr_pkg::ENC_BYTE;     info.src = 5'd10; end
      8'h0C: begin info.enc = obdpr_pkg::ENC_RPM;      info.src = 5'd11; end
      8'h0D: begin info.enc = obdpr_pkg::ENC_BYTE;     info.src = 5'd12; end
      8'h0E: begin info.enc = obdpr_pkg::ENC_TIMING;   info.src = 5'd13; end
      8'h0F: begin info.enc = obdpr_pkg::ENC_TEMP;     info.src = 5'd14; end
      8'h10: begin info.enc = obdpr_pkg::ENC_HALF;     info.src = 5'd15; end
      8'h11: begin info.enc = obdpr_pkg::ENC_PERCENT;  info.src = 5'd16; end
      8'h1C: begin info.enc = obdpr_pkg::ENC_BYTE;     info.src = 5'd17; end
      8'h1F: begin info.enc = obdpr_pkg::ENC_HALF;     info.src = 5'd18; end
      8'h21: begin info.enc = obdpr_pkg::ENC_HALF;     info.src = 5'd19; end
      8'h2F: begin info.enc = obdpr_pkg::ENC_PERCENT;  info.src = 5'd20; end
      8'h31: begin info.enc = obdpr_pkg::ENC_HALF;     info.src = 5'd21; end
      8'h33: begin info.enc = obdpr_pkg::ENC_BYTE;     info.src = 5'd22; end
      8'h42: begin info.enc = obdpr_pkg::ENC_HALF;     info.src = 5'd23; end
      8'h46: begin info.enc = obdpr_pkg::ENC_TEMP;     info.src = 5'd24; end
      8'h47: begin info.enc = obdpr_pkg::ENC_PERCENT;  info.src = 5'd25; end
      8'h4C: begin info.enc = obdpr_pkg::ENC_PERCENT;  info.src = 5'd26; end
      8'h4D: begin info.enc = obdpr_pkg::ENC_HALF;     info.src = 5'd27; end
      8'h4E: begin info.enc = obdpr_pkg::ENC_HALF;     info.src = 5'd28; end
      8'h52: begin info.enc = obdpr_pkg::ENC_PERCENT;  info.src = 5'd29; end
      8'h5C: begin info.enc = obdpr_pkg::ENC_TEMP;     info.src = 5'd30; end
      8'h5E: begin info.enc = obdpr_pkg::ENC_DIV5;     info.src = 5'd31; end
      default: info.enc = obdpr_pkg::ENC_NONE;
    endcase
    return info;
  endfunction

  logic [7:0]            pid_eff;
  obdpr_pkg::pid_info_t  info;
  logic [31:0]           raw;
  logic [7:0]            low8;
  logic [15:0]           low16;

  // two-byte requests carry no pid
  assign pid_eff = (req.len >= 4'd3) ? req.pid : 8'h00;
  assign info    = pid_lookup(pid_eff);
  assign raw     = values[info.src];
  assign low8    = raw[7:0];
  assign low16   = raw[15:0];

  // percent: low8 * 255 / 100, anything above 100 saturates
  logic [15:0] pct_x;
  logic [27:0] pct_prod;
  logic [7:0]  pct_byte;
  assign pct_x    = 16'(low8) * 16'd255;
  assign pct_prod = 28'(pct_x[14:0]) * 28'(PCT_RECIP);
  assign pct_byte = (low8 > 8'd100) ? 8'hFF : pct_prod[26:19];

  // temperature: s16 + 40
  logic signed [16:0] temp_s;
  logic [7:0]         temp_byte;
  assign temp_s = $signed({low16[15], low16}) + 17'sd40;
  always_comb begin
    if (temp_s < 17'sd0) begin
      temp_byte = 8'h00;
    end else if (temp_s > 17'sd255) begin
      temp_byte = 8'hFF;
    end else begin
      temp_byte = temp_s[7:0];
    end
  end

  // trim: 128 + s8 * 128 / 100, quotient truncated toward zero
  logic [7:0]  trim_mag;
  logic [27:0] trim_prod;
  logic [7:0]  trim_q;
  logic [8:0]  trim_pos;
  logic [7:0]  trim_byte;
  assign trim_mag  = low8[7] ? (~low8 + 8'd1) : low8;
  assign trim_prod = 28'({trim_mag, 7'b0}) * 28'(PCT_RECIP);
  assign trim_q    = trim_prod[26:19];
  assign trim_pos  = 9'd128 + 9'(trim_q);
  always_comb begin
    if (low8[7]) begin
      trim_byte = (trim_q > 8'd128) ? 8'h00 : 8'(9'd128 - 9'(trim_q));
    end else begin
      trim_byte = (trim_pos > 9'd255) ? 8'hFF : trim_pos[7:0];
    end
  end

  // timing: (s8 + 64) * 2
  logic signed [9:0] tim_base;
  logic signed [9:0] tim_s;
  logic [7:0]        tim_byte;
  assign tim_base = $signed({{2{low8[7]}}, low8}) + 10'sd64;
  assign tim_s    = $signed({tim_base[8:0], 1'b0});
  always_comb begin
    if (tim_s < 10'sd0) begin
      tim_byte = 8'h00;
    end else if (tim_s > 10'sd255) begin
      tim_byte = 8'hFF;
    end else begin
      tim_byte = tim_s[7:0];
    end
  end

  // fuel pressure: low16 / 3, saturating from 768 up
  logic [19:0] div3_prod;
  logic [7:0]  div3_byte;
  assign div3_prod = 20'(low16[9:0]) * 20'(DIV3_RECIP);
  assign div3_byte = (low16 >= 16'd768) ? 8'hFF : div3_prod[18:11];

  // fuel rate: low16 / 5
  logic [31:0] div5_prod;
  logic [15:0] div5_half;
  assign div5_prod = 32'(low16) * 32'(DIV5_RECIP);
  assign div5_half = 16'(div5_prod[31:18]);

  // data bytes, first byte in the top
  logic [31:0] dw;
  logic [2:0]  dn;
  always_comb begin
    dw = 32'd0;
    dn = 3'd0;
    unique case (info.enc)
      obdpr_pkg::ENC_BITMAP:   begin dw = info.bitmap; dn = 3'd4; end
      obdpr_pkg::ENC_WORD:     begin dw = raw; dn = 3'd4; end
      obdpr_pkg::ENC_FUEL_SYS: begin dw = {low8, values[2][7:0], 16'd0}; dn = 3'd2; end
      obdpr_pkg::ENC_PERCENT:  begin dw = {pct_byte, 24'd0}; dn = 3'd1; end
      obdpr_pkg::ENC_TEMP:     begin dw = {temp_byte, 24'd0}; dn = 3'd1; end
      obdpr_pkg::ENC_TRIM:     begin dw = {trim_byte, 24'd0}; dn = 3'd1; end
      obdpr_pkg::ENC_TIMING:   begin dw = {tim_byte, 24'd0}; dn = 3'd1; end
      obdpr_pkg::ENC_DIV3:     begin dw = {div3_byte, 24'd0}; dn = 3'd1; end
      obdpr_pkg::ENC_BYTE:     begin dw = {low8, 24'd0}; dn = 3'd1; end
      obdpr_pkg::ENC_RPM:      begin dw = {low16[13:0], 2'b00, 16'd0}; dn = 3'd2; end
      obdpr_pkg::ENC_HALF:     begin dw = {low16, 16'd0}; dn = 3'd2; end
      obdpr_pkg::ENC_DIV5:     begin dw = {div5_half, 16'd0}; dn = 3'd2; end
      default:                 begin dw = 32'd0; dn = 3'd0; end
    endcase
  end

  // trouble code lists
  logic              is_code_mode;
  logic [2:0][15:0]  list_codes;
  logic [7:0]        list_count;
  logic [1:0]        code_cnt;
  always_comb begin
    is_code_mode = 1'b1;
    unique case (req.mode)
      obdpr_pkg::MODE_STORED: begin
        list_codes = {codes[2], codes[1], codes[0]};
        list_count = counts[0];
      end
      obdpr_pkg::MODE_PENDING: begin
        list_codes = {codes[5], codes[4], codes[3]};
        list_count = counts[1];
      end
      obdpr_pkg::MODE_PERMANENT: begin
        list_codes = {codes[8], codes[7], codes[6]};
        list_count = counts[2];
      end
      default: begin
        is_code_mode = 1'b0;
        list_codes   = {codes[2], codes[1], codes[0]};
        list_count   = counts[0];
      end
    endcase
  end
  assign code_cnt = (list_count > 8'(CODE_LIM)) ? CODE_LIM : list_count[1:0];

  logic [3:0] plen;
  always_comb begin
    resp       = '0;
    plen       = 4'd0;
    resp.frame = 1'b0;
    if (req.mode == obdpr_pkg::MODE_CURRENT) begin
      resp.frame    = (req.len >= 4'd2) && (info.enc != obdpr_pkg::ENC_NONE);
      plen          = 4'(dn) + 4'd2;
      resp.bytes[1] = obdpr_pkg::MODE_CURRENT + obdpr_pkg::SERVICE_OFS;
      resp.bytes[2] = pid_eff;
      resp.bytes[3] = dw[31:24];
      resp.bytes[4] = dw[23:16];
      resp.bytes[5] = dw[15:8];
      resp.bytes[6] = dw[7:0];
    end else if (is_code_mode) begin
      resp.frame    = (req.len >= 4'd2);
      resp.bytes[1] = req.mode + obdpr_pkg::SERVICE_OFS;
      // an empty list still sends two zero bytes
      plen = (list_count == 8'd0) ? 4'd3 : 4'd1 + {1'b0, code_cnt, 1'b0};
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < code_cnt) begin
          resp.bytes[2 + 2 * i] = list_codes[i][15:8];
          resp.bytes[3 + 2 * i] = list_codes[i][7:0];
        end
      end
    end
    resp.bytes[0] = 8'(plen);
    resp.len      = plen + 4'd1;
    resp.id       = (req.id[10:3] == obdpr_pkg::ID_REQ_BASE[10:3])
                    ? req.id + obdpr_pkg::ID_RESP_OFS : obdpr_pkg::ID_RESP_DFLT;
  end

endmodule

`default_nettype wire

### tb/obd_pid_request_responder_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// obd_pid_request_responder_checker
// Watches both stream channels of the responder, keeps its own copy of the
// value table, trouble codes and code counts, predicts the response frame for
// every request transfer and compares each frame field by field in order.
// ----------------------------------------------------------------------------

module obd_pid_request_responder_checker
  import obdpr_pkg::*;
#(
  parameter int unsigned CODES_PER_LIST = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // req_id req_len req_mode req_pid slot slot_value, from bit 0 up
  input  logic [71:0] in_tdata,
  // func
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // resp_id resp_len byte0 byte1 .. byte7, from bit 0 up
  input  logic [79:0] out_tdata,
  output int          fail_count,
  output int          frames_pending
);

  localparam int unsigned CODES_IN_LIST = NUM_CODES / NUM_LISTS;
  localparam int unsigned LIST_DEPTH    =
    (CODES_PER_LIST > CODES_IN_LIST) ? CODES_IN_LIST : CODES_PER_LIST;
  localparam int          TEMP_OFFSET   = 40;
  localparam int          TRIM_CENTER   = 128;
  localparam int          TIMING_OFFSET = 64;
  localparam int          MAX_DLC       = 8;
  localparam int          MAX_PRINTS    = 100;
  localparam logic [10:0] ID_REQ_LAST   = ID_REQ_BASE + ID_RESP_OFS - 11'd1;

  localparam logic [7:0]
    PID_SUPPORT_00      = 8'h00, PID_MONITOR_STATUS = 8'h01, PID_FUEL_SYSTEM    = 8'h03,
    PID_ENGINE_LOAD     = 8'h04, PID_COOLANT_TEMP   = 8'h05, PID_SHORT_TRIM_1   = 8'h06,
    PID_LONG_TRIM_1     = 8'h07, PID_SHORT_TRIM_2   = 8'h08, PID_LONG_TRIM_2    = 8'h09,
    PID_FUEL_PRESSURE   = 8'h0A, PID_INTAKE_PRESS   = 8'h0B, PID_ENGINE_RPM     = 8'h0C,
    PID_VEHICLE_SPEED   = 8'h0D, PID_TIMING_ADVANCE = 8'h0E, PID_INTAKE_TEMP    = 8'h0F,
    PID_MAF_RATE        = 8'h10, PID_THROTTLE       = 8'h11, PID_OBD_STANDARD   = 8'h1C,
    PID_RUN_TIME        = 8'h1F, PID_SUPPORT_20     = 8'h20, PID_DIST_MIL       = 8'h21,
    PID_FUEL_LEVEL      = 8'h2F, PID_DIST_CLEAR     = 8'h31, PID_BARO           = 8'h33,
    PID_SUPPORT_40      = 8'h40, PID_MODULE_VOLTAGE = 8'h42, PID_AMBIENT_TEMP   = 8'h46,
    PID_ABS_THROTTLE_B  = 8'h47, PID_CMD_THROTTLE   = 8'h4C, PID_TIME_MIL       = 8'h4D,
    PID_TIME_CLEAR      = 8'h4E, PID_ETHANOL        = 8'h52, PID_OIL_TEMP       = 8'h5C,
    PID_FUEL_RATE       = 8'h5E, PID_SUPPORT_60     = 8'h60;

  logic [31:0] vehicle_values [NUM_VALUES];
  logic [15:0] trouble_codes  [NUM_CODES];
  logic [7:0]  code_counts    [NUM_LISTS];
  resp_t       frames_due     [$];

  function automatic logic [7:0] clamp_byte(input int v);
    if (v < 0) return '0;
    if (v > 255) return '1;
    return v[7:0];
  endfunction

  function automatic pid_info_t pid_entry(input enc_t enc, input logic [4:0] src,
                                          input logic [31:0] bitmap = '0);
    pid_info_t e;
    e.enc    = enc;
    e.src    = src;
    e.bitmap = bitmap;
    return e;
  endfunction

  function automatic pid_info_t lookup_pid(input logic [7:0] pid);
    case (pid)
      PID_SUPPORT_00:     return pid_entry(ENC_BITMAP, 5'd0, BITMAP_00);
      PID_SUPPORT_20:     return pid_entry(ENC_BITMAP, 5'd0, BITMAP_20);
      PID_SUPPORT_40:     return pid_entry(ENC_BITMAP, 5'd0, BITMAP_40);
      PID_SUPPORT_60:     return pid_entry(ENC_BITMAP, 5'd0, BITMAP_60);
      PID_MONITOR_STATUS: return pid_entry(ENC_WORD, 5'd0);
      PID_FUEL_SYSTEM:    return pid_entry(ENC_FUEL_SYS, 5'd1);
      PID_ENGINE_LOAD:    return pid_entry(ENC_PERCENT, 5'd3);
      PID_COOLANT_TEMP:   return pid_entry(ENC_TEMP, 5'd4);
      PID_SHORT_TRIM_1:   return pid_entry(ENC_TRIM, 5'd5);
      PID_LONG_TRIM_1:    return pid_entry(ENC_TRIM, 5'd6);
      PID_SHORT_TRIM_2:   return pid_entry(ENC_TRIM, 5'd7);
      PID_LONG_TRIM_2:    return pid_entry(ENC_TRIM, 5'd8);
      PID_FUEL_PRESSURE:  return pid_entry(ENC_DIV3, 5'd9);
      PID_INTAKE_PRESS:   return pid_entry(ENC_BYTE, 5'd10);
      PID_ENGINE_RPM:     return pid_entry(ENC_RPM, 5'd11);
      PID_VEHICLE_SPEED:  return pid_entry(ENC_BYTE, 5'd12);
      PID_TIMING_ADVANCE: return pid_entry(ENC_TIMING, 5'd13);
      PID_INTAKE_TEMP:    return pid_entry(ENC_TEMP, 5'd14);
      PID_MAF_RATE:       return pid_entry(ENC_HALF, 5'd15);
      PID_THROTTLE:       return pid_entry(ENC_PERCENT, 5'd16);
      PID_OBD_STANDARD:   return pid_entry(ENC_BYTE, 5'd17);
      PID_RUN_TIME:       return pid_entry(ENC_HALF, 5'd18);
      PID_DIST_MIL:       return pid_entry(ENC_HALF, 5'd19);
      PID_FUEL_LEVEL:     return pid_entry(ENC_PERCENT, 5'd20);
      PID_DIST_CLEAR:     return pid_entry(ENC_HALF, 5'd21);
      PID_BARO:           return pid_entry(ENC_BYTE, 5'd22);
      PID_MODULE_VOLTAGE: return pid_entry(ENC_HALF, 5'd23);
      PID_AMBIENT_TEMP:   return pid_entry(ENC_TEMP, 5'd24);
      PID_ABS_THROTTLE_B: return pid_entry(ENC_PERCENT, 5'd25);
      PID_CMD_THROTTLE:   return pid_entry(ENC_PERCENT, 5'd26);
      PID_TIME_MIL:       return pid_entry(ENC_HALF, 5'd27);
      PID_TIME_CLEAR:     return pid_entry(ENC_HALF, 5'd28);
      PID_ETHANOL:        return pid_entry(ENC_PERCENT, 5'd29);
      PID_OIL_TEMP:       return pid_entry(ENC_TEMP, 5'd30);
      PID_FUEL_RATE:      return pid_entry(ENC_DIV5, 5'd31);
      default:            return pid_entry(ENC_NONE, 5'd0);
    endcase
  endfunction

  // data bytes of a current-data answer, first byte in the highest used bits
  function automatic logic [31:0] encode_pid(input pid_info_t info, output int nbytes);
    logic [31:0] raw;
    int          signed_raw;
    raw    = vehicle_values[info.src];
    nbytes = 1;
    case (info.enc)
      ENC_BITMAP: begin
        nbytes = 4;
        return info.bitmap;
      end
      ENC_WORD: begin
        nbytes = 4;
        return raw;
      end
      ENC_FUEL_SYS: begin
        nbytes = 2;
        return {16'd0, raw[7:0], vehicle_values[info.src + 5'd1][7:0]};
      end
      ENC_PERCENT: return clamp_byte(int'(raw[7:0]) * 255 / 100);
      ENC_TEMP: begin
        signed_raw = $signed(raw[15:0]);
        return clamp_byte(signed_raw + TEMP_OFFSET);
      end
      ENC_TRIM: begin
        // int division truncates toward zero, as the encoding requires
        signed_raw = $signed(raw[7:0]);
        return clamp_byte(TRIM_CENTER + signed_raw * 128 / 100);
      end
      ENC_TIMING: begin
        signed_raw = $signed(raw[7:0]);
        return clamp_byte((signed_raw + TIMING_OFFSET) * 2);
      end
      ENC_DIV3: return clamp_byte(int'(raw[15:0]) / 3);
      ENC_BYTE: return {24'd0, raw[7:0]};
      ENC_RPM: begin
        nbytes = 2;
        return {16'd0, raw[13:0], 2'b00};
      end
      ENC_HALF: begin
        nbytes = 2;
        return {16'd0, raw[15:0]};
      end
      ENC_DIV5: begin
        nbytes = 2;
        return {16'd0, raw[15:0] / 16'd5};
      end
      default: return '0;
    endcase
  endfunction

  // updates the tables or queues the frame a request should produce
  function automatic void apply_item(input logic func, input logic [71:0] data);
    logic [10:0]     id;
    logic [3:0]      len;
    logic [7:0]      mode;
    logic [7:0]      pid;
    logic [5:0]      slot;
    logic [31:0]     val;
    logic [15:0]     code;
    logic [6:0][7:0] pay;
    logic [31:0]     word;
    int              nbytes;
    int              plen;
    int              list;
    int              shown;
    pid_info_t       info;
    resp_t           frame;
    id   = data[10:0];
    len  = data[14:11];
    mode = data[22:15];
    pid  = data[30:23];
    slot = data[36:31];
    val  = data[68:37];
    pay  = '0;
    plen = 0;
    if (func) begin
      if (slot < SLOT_CODE_BASE) vehicle_values[slot] = val;
      else if (slot < SLOT_COUNT_BASE) trouble_codes[slot - SLOT_CODE_BASE] = val[15:0];
      else if (slot < SLOT_END) code_counts[slot - SLOT_COUNT_BASE] = val[7:0];
      return;
    end
    if (len < 4'd2) return;
    if (len < 4'd3) pid = '0;
    if (mode == MODE_CURRENT) begin
      info = lookup_pid(pid);
      if (info.enc == ENC_NONE) return;
      word   = encode_pid(info, nbytes);
      pay[0] = MODE_CURRENT + SERVICE_OFS;
      pay[1] = pid;
      for (int i = 0; i < nbytes; i++) pay[2 + i] = word[8 * (nbytes - 1 - i) +: 8];
      plen = nbytes + 2;
    end else if (mode == MODE_STORED || mode == MODE_PENDING || mode == MODE_PERMANENT) begin
      list  = (mode == MODE_STORED) ? 0 : (mode == MODE_PENDING) ? 1 : 2;
      shown = (code_counts[list] > LIST_DEPTH) ? LIST_DEPTH : code_counts[list];
      pay[0] = mode + SERVICE_OFS;
      plen   = 1;
      for (int i = 0; i < shown; i++) begin
        code          = trouble_codes[list * CODES_IN_LIST + i];
        pay[plen]     = code[15:8];
        pay[plen + 1] = code[7:0];
        plen += 2;
      end
      // an empty list still answers with two zero bytes
      if (code_counts[list] == 0) plen += 2;
    end else begin
      return;
    end
    frame       = '0;
    frame.frame = 1'b1;
    frame.id    = (id >= ID_REQ_BASE && id <= ID_REQ_LAST) ? id + ID_RESP_OFS : ID_RESP_DFLT;
    frame.len   = (plen >= MAX_DLC) ? MAX_DLC : plen + 1;
    frame.bytes[0] = plen;
    for (int i = 0; i < 7; i++) frame.bytes[1 + i] = pay[i];
    frames_due.push_back(frame);
  endfunction

  task automatic report_fail(input string msg);
    if (fail_count < MAX_PRINTS) $display("[%0t] %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_frame(input resp_t got, input resp_t want);
    if (got.id !== want.id)
      report_fail($sformatf("resp_id got 0x%0h expected 0x%0h", got.id, want.id));
    if (got.len !== want.len)
      report_fail($sformatf("resp_len got %0d expected %0d", got.len, want.len));
    for (int i = 0; i < 8; i++)
      if (got.bytes[i] !== want.bytes[i])
        report_fail($sformatf("byte%0d got 0x%0h expected 0x%0h (resp_id 0x%0h)",
                              i, got.bytes[i], want.bytes[i], want.id));
  endtask

  always @(posedge clk) begin : watch
    resp_t got;
    if (!rst_n) begin
      for (int i = 0; i < NUM_VALUES; i++) vehicle_values[i] = '0;
      for (int i = 0; i < NUM_CODES; i++) trouble_codes[i] = '0;
      for (int i = 0; i < NUM_LISTS; i++) code_counts[i] = '0;
      frames_due.delete();
      fail_count = 0;
    end else begin
      // the frame leaving now can only belong to an earlier request
      if (out_tvalid && out_tready) begin
        got       = '0;
        got.frame = 1'b1;
        got.id    = out_tdata[10:0];
        got.len   = out_tdata[14:11];
        for (int i = 0; i < 8; i++) got.bytes[i] = out_tdata[15 + 8 * i +: 8];
        if (frames_due.size() == 0)
          report_fail($sformatf("frame with resp_id 0x%0h while none was due", got.id));
        else
          check_frame(got, frames_due.pop_front());
      end
      if (in_tvalid && in_tready) apply_item(in_tuser, in_tdata);
    end
    frames_pending = frames_due.size();
  end

endmodule

### tb/obd_pid_request_responder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// obd_pid_request_responder_tb
// Drives value updates and diagnostic requests into the responder, first a
// directed set of corner cases, then random traffic under several idle and
// back-pressure mixes; the checker beside the block judges every frame.
// ----------------------------------------------------------------------------

module obd_pid_request_responder_tb;
  import obdpr_pkg::*;

  localparam int         ITEMS_PER_PHASE  = 144;
  localparam int         NUM_PHASES       = 8;
  localparam int         DRAIN_CYCLES     = 10;
  localparam logic [7:0] LAST_SUPPORT_PID = 8'h60;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;
  int          fail_count;
  int          frames_pending;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned idle_plan  [4] = '{0, 85, 0, 15};
  int unsigned stall_plan [4] = '{0, 0, 85, 15};

  obd_pid_request_responder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  obd_pid_request_responder_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .fail_count     (fail_count),
    .frames_pending (frames_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input logic func, input logic [71:0] data);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // unused fields carry random bits
  task automatic send_request(input logic [10:0] id, input logic [3:0] len,
                              input logic [7:0] mode, input logic [7:0] pid);
    logic [5:0]  slot;
    logic [31:0] val;
    slot = $urandom;
    val  = $urandom;
    send_item(1'b0, {3'b000, val, slot, pid, mode, len, id});
  endtask

  task automatic send_write(input logic [5:0] slot, input logic [31:0] val);
    logic [30:0] noise;
    noise = $urandom;
    send_item(1'b1, {3'b000, val, slot, noise});
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 400) - 200;
      2: return $urandom_range(0, 255);
      3: begin
        case ($urandom_range(0, 7))
          0:       return '0;
          1:       return '1;
          2:       return 32'h0000_007F;
          3:       return 32'h0000_0080;
          4:       return 32'h0000_7FFF;
          5:       return 32'h0000_8000;
          6:       return 32'h0000_00FF;
          default: return 32'h0000_FFFF;
        endcase
      end
      default: return $urandom & 32'h0000_FFFF;
    endcase
  endfunction

  initial begin : stimulus
    logic [5:0]  slot;
    logic [31:0] val;
    logic [10:0] id;
    logic [3:0]  len;
    logic [7:0]  mode;
    logic [7:0]  pid;
    int          r;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    out_tready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // corner writes: value extremes, code and count truncation, ignored slots
    send_write(6'd0, '1);
    send_write(NUM_VALUES - 1, 32'h0000_8000);
    send_write(SLOT_CODE_BASE, '1);
    send_write(SLOT_CODE_BASE + 6'd6, 32'hABCD_1234);
    send_write(SLOT_COUNT_BASE - 6'd1, 32'h1234_0000);
    send_write(SLOT_COUNT_BASE, '1);
    send_write(SLOT_END - 6'd1, 32'h0000_0101);
    send_write('1, '1);
    send_write(SLOT_END, 32'h0000_0005);

    // length 2 drops the pid, short lengths give nothing
    send_request(ID_REQ_BASE, 4'd2, MODE_CURRENT, '1);
    send_request('1, 4'd0, MODE_CURRENT, '0);
    send_request('0, 4'd1, MODE_STORED, '0);
    send_request(ID_REQ_BASE + 11'd7, 4'd15, MODE_CURRENT, '1);
    send_request(ID_REQ_BASE - 11'd1, 4'd8, MODE_CURRENT, '0);
    send_request('1, 4'd9, MODE_CURRENT, '0);
    // stored list over its limit, pending list empty, permanent with one code
    send_request(ID_RESP_DFLT, 4'd3, MODE_STORED, '0);
    send_request(ID_REQ_BASE + 11'd3, 4'd8, MODE_PENDING, '0);
    send_request(ID_REQ_BASE + 11'd7, 4'd2, MODE_PERMANENT, '1);
    send_request(ID_REQ_BASE, 4'd8, '0, '0);
    send_request(ID_REQ_BASE, 4'd8, '1, '1);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      send_idle_pct  = idle_plan[phase % 4];
      recv_stall_pct = stall_plan[phase % 4];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) < 35) begin
          r = $urandom_range(0, 99);
          if (r < 55) slot = $urandom_range(0, SLOT_CODE_BASE - 1);
          else if (r < 80) slot = $urandom_range(SLOT_CODE_BASE, SLOT_COUNT_BASE - 1);
          else if (r < 93) slot = $urandom_range(SLOT_COUNT_BASE, SLOT_END - 1);
          else slot = $urandom_range(SLOT_END, 63);
          // counts mostly near the list depth
          if (slot >= SLOT_COUNT_BASE && slot < SLOT_END && $urandom_range(0, 3) != 0)
            val = $urandom_range(0, 5);
          else
            val = pick_value();
          send_write(slot, val);
        end else begin
          if ($urandom_range(0, 99) < 55) id = ID_REQ_BASE + $urandom_range(0, 7);
          else id = $urandom;
          r = $urandom_range(0, 99);
          if (r < 8) len = $urandom_range(0, 2);
          else if (r < 16) len = $urandom_range(9, 15);
          else len = $urandom_range(3, 8);
          r = $urandom_range(0, 99);
          if (r < 60) mode = MODE_CURRENT;
          else if (r < 70) mode = MODE_STORED;
          else if (r < 80) mode = MODE_PENDING;
          else if (r < 90) mode = MODE_PERMANENT;
          else mode = $urandom;
          if ($urandom_range(0, 99) < 90) pid = $urandom_range(0, LAST_SUPPORT_PID);
          else pid = $urandom;
          send_request(id, len, mode, pid);
        end
      end
    end

    in_tvalid      <= 1'b0;
    recv_stall_pct = 0;
    while (frames_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
